// File: design/sample_rank_statistics_unit_macros.svh
// ---------------------------------------------------------------------------
// sample rank statistics assertion macros
// ---------------------------------------------------------------------------
`ifndef SAMPLE_RANK_STATISTICS_UNIT_MACROS_SVH
`define SAMPLE_RANK_STATISTICS_UNIT_MACROS_SVH

// implication in the same cycle
`define SRS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// implication in the next cycle
`define SRS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/srs_pkg.sv
// ---------------------------------------------------------------------------
// srs_pkg
// shared types and constants of the sample rank statistics unit
// ---------------------------------------------------------------------------
package srs_pkg;

    localparam int TRIM_BITS  = 8;
    localparam int DISC_BITS  = 16;
    localparam int P95_NUM    = 95;
    localparam int P95_DEN    = 100;
    localparam int PCT_BITS   = 7;

    typedef enum logic [4:0] {
        S_LOAD  = 5'b00001,
        S_PREP  = 5'b00010,
        S_DRAIN = 5'b00100,
        S_DIV   = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    typedef struct packed {
        logic ins;
        logic shift;
    } t_cell_ctl;

endpackage

// File: design/srs_if.sv
// ---------------------------------------------------------------------------
// srs_if
// request and result channels of the sample rank statistics unit
// ---------------------------------------------------------------------------
interface srs_sample_if #(
    parameter int SAMPLE_BITS = 32
);
    import srs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_value;
    logic                   sample_present;
    logic                   batch_last;
    logic [DISC_BITS-1:0]   discarded_count;

    modport source (output valid, sample_value, sample_present, batch_last,
                    discarded_count, input ready);
    modport sink   (input valid, sample_value, sample_present, batch_last,
                    discarded_count, output ready);
endinterface

interface srs_result_if #(
    parameter int SAMPLE_BITS = 32,
    parameter int COUNT_BITS  = 11
);
    import srs_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [COUNT_BITS-1:0]  sample_count;
    logic [SAMPLE_BITS-1:0] min_value;
    logic [SAMPLE_BITS-1:0] median_value;
    logic [SAMPLE_BITS-1:0] p95_value;
    logic [SAMPLE_BITS-1:0] trimmed_mean;
    logic [DISC_BITS-1:0]   discarded_out;
    logic                   overflowed;

    modport source (output valid, sample_count, min_value, median_value, p95_value,
                    trimmed_mean, discarded_out, overflowed, input ready);
    modport sink   (input valid, sample_count, min_value, median_value, p95_value,
                    trimmed_mean, discarded_out, overflowed, output ready);
endinterface

// File: design/srs_cell.sv
// ---------------------------------------------------------------------------
// srs_cell
// one slot of the insertion sort chain, shifts toward the head on drain
// ---------------------------------------------------------------------------
module srs_cell #(
    parameter int SAMPLE_BITS = 32
) (
    input  logic                   i_clk,
    input  srs_pkg::t_cell_ctl     i_ctl,
    input  logic                   i_occ,
    input  logic                   i_here,
    input  logic [SAMPLE_BITS-1:0] i_v,
    input  logic                   i_left_gt,
    input  logic [SAMPLE_BITS-1:0] i_left_val,
    input  logic [SAMPLE_BITS-1:0] i_right_val,
    output logic                   o_gt,
    output logic [SAMPLE_BITS-1:0] o_val
);
    import srs_pkg::*;

    logic [SAMPLE_BITS-1:0] r_val;
    logic [SAMPLE_BITS-1:0] n_val;

    assign o_gt  = i_occ && (r_val > i_v);
    assign o_val = r_val;

    always_comb begin
        n_val = r_val;
        if (i_ctl.shift) begin
            n_val = i_right_val;
        end else if (i_ctl.ins) begin
            if (i_left_gt) begin
                n_val = i_left_val;
            end else if (o_gt || i_here) begin
                n_val = i_v;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_val <= n_val;
    end
endmodule

// File: design/srs_div.sv
// ---------------------------------------------------------------------------
// srs_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module srs_div #(
    parameter int DW = 43,
    parameter int CW = 11
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [CW-1:0] i_divisor,
    output logic          o_done,
    output logic [DW-1:0] o_quot
);
    import srs_pkg::*;

    localparam int NW = $clog2(DW + 1);

    logic          r_busy;
    logic [NW-1:0] r_cnt;
    logic [CW-1:0] r_rem;
    logic [DW-1:0] r_quo;
    logic [CW-1:0] r_div;
    logic          r_done;
    logic [CW:0]   w_trial;
    logic          w_ge;

    assign w_trial = {r_rem, r_quo[DW-1]};
    assign w_ge    = w_trial >= {1'b0, r_div};
    assign o_done  = r_done;
    assign o_quot  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? CW'(w_trial - {1'b0, r_div}) : w_trial[CW-1:0];
            r_quo <= {r_quo[DW-2:0], w_ge};
        end
    end
endmodule

// File: design/sample_rank_statistics_unit.sv
// ---------------------------------------------------------------------------
// sample_rank_statistics_unit
// batch min, median, p95 and trimmed mean over a sorted sample chain
// ---------------------------------------------------------------------------
// usage:
//   i_smp carries one sample request per cycle; each present sample is put in
//   order into a chain of MAX_SAMPLES cells in the cycle it is taken, so loading
//   runs at one request per cycle. samples past capacity are dropped and flagged.
//   a request with batch_last closes the batch: the chain is then read out from
//   its head, one cell per cycle, taking min, median, p95 and the trimmed sum,
//   and a restoring divider gives the mean one bit per cycle.
//   the divider is skipped when trimming leaves nothing, and an empty batch
//   goes straight to the result.
//   i_smp.ready is low from the closing request until the result is registered.
//   the result sits in an output register on o_res; while the receiver stalls,
//   the next batch still loads and closes, and its result then waits with
//   i_smp.ready low until the output register is free. i_cfg_we writes
//   trim_fraction; the user must do so only while the block is idle, unenforced.
//   reset (synchronous, active low) empties the batch and clears trim_fraction.
// ---------------------------------------------------------------------------
`include "sample_rank_statistics_unit_macros.svh"

module sample_rank_statistics_unit #(
    parameter int MAX_SAMPLES = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [srs_pkg::TRIM_BITS-1:0]  i_cfg_wdata,
    srs_sample_if.sink                     i_smp,
    srs_result_if.source                   o_res
);
    import srs_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int PW = CW + PCT_BITS;
    localparam int DW = SAMPLE_BITS + CW;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SAMPLES);

    t_state                 r_state;
    logic [TRIM_BITS-1:0]   r_trim;
    logic [CW-1:0]          r_count;
    logic                   r_ovf;
    logic [CW-1:0]          r_n;
    logic [CW-1:0]          r_k;
    logic [CW-1:0]          r_cut;
    logic [PW-1:0]          r_p95lim;
    logic [PW-1:0]          r_k100;
    logic [DW-1:0]          r_sum;
    logic [SAMPLE_BITS-1:0] r_min;
    logic [SAMPLE_BITS-1:0] r_med;
    logic [SAMPLE_BITS-1:0] r_p95;
    logic [SAMPLE_BITS-1:0] r_tm;
    logic [DISC_BITS-1:0]   r_disc;
    logic                   r_bovf;
    logic                   r_out_valid;
    logic                   r_div_go;

    logic                   w_acc;
    logic                   w_full;
    logic                   w_ins;
    logic                   w_out_free;
    logic [CW+TRIM_BITS-1:0] w_prod;
    logic                   w_win_ok;
    logic [CW-1:0]          w_len;
    logic                   w_div_start;
    logic                   w_div_done;
    logic [DW-1:0]          w_quot;
    t_cell_ctl              w_ctl;

    logic [SAMPLE_BITS-1:0] w_val [MAX_SAMPLES];
    logic                   w_gt  [MAX_SAMPLES];

    assign i_smp.ready = (r_state == S_LOAD);
    assign w_acc       = i_smp.valid && i_smp.ready;
    assign w_full      = (r_count == MAX_C);
    assign w_ins       = w_acc && i_smp.sample_present && !w_full;
    assign w_out_free  = !r_out_valid || o_res.ready;
    assign w_prod      = (CW+TRIM_BITS)'(r_n) * (CW+TRIM_BITS)'(r_trim);
    assign w_win_ok    = {r_cut, 1'b0} < {1'b0, r_n};
    assign w_len       = r_n - CW'({r_cut, 1'b0});
    assign w_div_start = (r_state == S_DRAIN) && (r_k == r_n - 1'b1) && w_win_ok;

    assign w_ctl.ins   = w_ins;
    assign w_ctl.shift = (r_state == S_DRAIN);

    genvar gi;
    generate
        for (gi = 0; gi < MAX_SAMPLES; gi++) begin : g_cell
            srs_cell #(.SAMPLE_BITS(SAMPLE_BITS)) u_cell (
                .i_clk       (i_clk),
                .i_ctl       (w_ctl),
                .i_occ       (CW'(gi) < r_count),
                .i_here      (CW'(gi) == r_count),
                .i_v         (i_smp.sample_value),
                .i_left_gt   ((gi == 0) ? 1'b0 : w_gt[(gi == 0) ? 0 : gi - 1]),
                .i_left_val  (w_val[(gi == 0) ? 0 : gi - 1]),
                .i_right_val ((gi == MAX_SAMPLES - 1) ? '0 :
                              w_val[(gi == MAX_SAMPLES - 1) ? gi : gi + 1]),
                .o_gt        (w_gt[gi]),
                .o_val       (w_val[gi])
            );
        end
    endgenerate

    srs_div #(.DW(DW), .CW(CW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_go),
        .i_dividend (r_sum),
        .i_divisor  (w_len),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_trim      <= '0;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_div_go    <= 1'b0;
        end else begin
            r_div_go <= w_div_start;
            if (i_cfg_we) begin
                r_trim <= i_cfg_wdata;
            end
            if (r_state == S_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_LOAD: begin
                    if (w_acc) begin
                        if (i_smp.batch_last) begin
                            r_count <= '0;
                            r_ovf   <= 1'b0;
                            if (r_count == '0 && !w_ins) begin
                                r_state <= S_DONE;
                            end else begin
                                r_state <= S_PREP;
                            end
                        end else begin
                            if (w_ins) begin
                                r_count <= r_count + 1'b1;
                            end
                            if (i_smp.sample_present && w_full) begin
                                r_ovf <= 1'b1;
                            end
                        end
                    end
                end
                S_PREP: begin
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (r_k == r_n - 1'b1) begin
                        r_state <= w_win_ok ? S_DIV : S_DONE;
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_state <= S_LOAD;
                    end
                end
                default: begin
                    r_state <= S_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_LOAD: begin
                if (w_acc && i_smp.batch_last) begin
                    r_n    <= r_count + CW'(w_ins);
                    r_bovf <= r_ovf || (i_smp.sample_present && w_full);
                    r_disc <= i_smp.discarded_count;
                    r_min  <= '0;
                    r_med  <= '0;
                    r_p95  <= '0;
                    r_tm   <= '0;
                end
            end
            S_PREP: begin
                r_cut    <= w_prod[CW+TRIM_BITS-1:TRIM_BITS];
                r_p95lim <= PW'(r_n) * PW'(P95_NUM);
                r_k100   <= '0;
                r_k      <= '0;
                r_sum    <= '0;
            end
            S_DRAIN: begin
                r_k    <= r_k + 1'b1;
                r_k100 <= r_k100 + PW'(P95_DEN);
                if (r_k == '0) begin
                    r_min <= w_val[0];
                end
                if (r_k == (r_n >> 1)) begin
                    r_med <= w_val[0];
                    if (!w_win_ok) begin
                        r_tm <= w_val[0];
                    end
                end
                if (r_k100 <= r_p95lim) begin
                    r_p95 <= w_val[0];
                end
                if (r_k >= r_cut && r_k < r_n - r_cut) begin
                    r_sum <= r_sum + DW'(w_val[0]);
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    r_tm <= w_quot[SAMPLE_BITS-1:0];
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    o_res.sample_count  <= r_n;
                    o_res.min_value     <= r_min;
                    o_res.median_value  <= r_med;
                    o_res.p95_value     <= r_p95;
                    o_res.trimmed_mean  <= r_tm;
                    o_res.discarded_out <= r_disc;
                    o_res.overflowed    <= r_bovf;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_res.valid = r_out_valid;

    `SRS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= MAX_C, "sample count above capacity")
    `SRS_ASSERT_NEXT(a_close_clears, w_acc && i_smp.batch_last, r_count == '0 && !r_ovf,
        "batch state not cleared after close")
    `SRS_ASSERT_NOW(a_div_in_state, w_div_done, r_state == S_DIV, "divider done outside divide")
    `SRS_ASSERT_NEXT(a_done_fills, r_state == S_DONE && w_out_free, r_out_valid,
        "result not presented")
endmodule

// File: dv/sample_rank_statistics_unit_test.sv
// ---------------------------------------------------------------------------
// sample_rank_statistics_unit_test
// drives sample batches with random gaps and stalls into the unit, predicts
// count, min, median, p95, trimmed mean, discarded count and overflow per
// batch and checks each result
module sample_rank_statistics_unit_test;
    timeunit 1ns;
    timeprecision 1ps;
    import srs_pkg::*;

    localparam int MAX_N = 1024;

    typedef struct packed {
        logic [10:0] cnt;
        logic [31:0] minv;
        logic [31:0] med;
        logic [31:0] p95;
        logic [31:0] tmean;
        logic [15:0] disc;
        logic        ovf;
    } t_stats;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [TRIM_BITS-1:0] i_cfg_wdata = '0;

    srs_sample_if #(.SAMPLE_BITS(32)) smp ();
    srs_result_if #(.SAMPLE_BITS(32), .COUNT_BITS(11)) res ();

    sample_rank_statistics_unit #(.MAX_SAMPLES(MAX_N), .SAMPLE_BITS(32)) i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata), .i_smp(smp.sink), .o_res(res.source)
    );

    logic [31:0] batch_sorted[$];
    logic        batch_ovf = 1'b0;
    logic [7:0]  trim_setting = '0;
    t_stats      stats_expected[$];
    int          mismatch_count = 0;
    bit          gaps_on = 1'b1;

    initial forever #5 i_clk = ~i_clk;

    initial begin
        #50ms;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        smp.valid = 1'b0;
        smp.sample_value = '0;
        smp.sample_present = 1'b0;
        smp.batch_last = 1'b0;
        smp.discarded_count = '0;
        res.ready = 1'b0;
    end

    task automatic report_mismatch(input string field, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", field, got, want, $realtime);
        mismatch_count++;
    endtask

    function automatic t_stats compute_stats(input logic [15:0] disc);
        t_stats s;
        int n;
        longint unsigned pi, cut, sum, len;
        s = '0;
        n = batch_sorted.size();
        s.cnt = n[10:0];
        s.disc = disc;
        s.ovf = batch_ovf;
        if (n > 0) begin
            pi = longint'(n) * P95_NUM / P95_DEN;
            if (pi > n - 1) pi = n - 1;
            cut = longint'(n) * trim_setting / 256;
            s.minv = batch_sorted[0];
            s.med = batch_sorted[n / 2];
            s.p95 = batch_sorted[pi];
            if (2 * cut < n) begin
                sum = 0;
                len = n - 2 * cut;
                for (int i = 0; i < len; i++) sum += batch_sorted[cut + i];
                s.tmean = 32'(sum / len);
            end else begin
                s.tmean = s.med;
            end
        end
        return s;
    endfunction

    function automatic void apply_request(input logic [31:0] v, input bit present,
                                          input bit last, input logic [15:0] disc);
        int pos;
        if (present) begin
            if (batch_sorted.size() < MAX_N) begin
                pos = batch_sorted.size();
                while (pos > 0 && batch_sorted[pos - 1] > v) pos--;
                batch_sorted.insert(pos, v);
            end else begin
                batch_ovf = 1'b1;
            end
        end
        if (last) begin
            stats_expected.insert(stats_expected.size(), compute_stats(disc));
            batch_sorted.delete();
            batch_ovf = 1'b0;
        end
    endfunction

    task automatic send_request(input logic [31:0] v, input bit present, input bit last,
                                input logic [15:0] disc);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge i_clk);
        end
        smp.valid <= 1'b1;
        smp.sample_value <= v;
        smp.sample_present <= present;
        smp.batch_last <= last;
        smp.discarded_count <= disc;
        do @(posedge i_clk); while (!smp.ready);
        apply_request(v, present, last, disc);
        @(negedge i_clk);
    endtask

    // result receiver with stall bursts
    initial begin
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (gaps_on && $urandom_range(0, 5) == 0) begin
                res.ready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(negedge i_clk);
            end
            res.ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_stats e;
        if (i_rst_n && res.valid && res.ready) begin
            if (stats_expected.size() == 0) begin
                report_mismatch("unexpected result", '0, '0);
            end else begin
                e = stats_expected.pop_front();
                if (res.sample_count !== e.cnt) report_mismatch("count", res.sample_count, e.cnt);
                if (res.min_value !== e.minv) report_mismatch("min", res.min_value, e.minv);
                if (res.median_value !== e.med) report_mismatch("median", res.median_value, e.med);
                if (res.p95_value !== e.p95) report_mismatch("p95", res.p95_value, e.p95);
                if (res.trimmed_mean !== e.tmean)
                    report_mismatch("trimmed mean", res.trimmed_mean, e.tmean);
                if (res.discarded_out !== e.disc)
                    report_mismatch("discarded", res.discarded_out, e.disc);
                if (res.overflowed !== e.ovf) report_mismatch("overflow", res.overflowed, e.ovf);
            end
        end
    end

    task automatic wait_idle();
        smp.valid <= 1'b0;
        while (stats_expected.size() != 0) @(negedge i_clk);
        repeat (2200) @(negedge i_clk);
    endtask

    task automatic write_trim(input logic [7:0] t);
        wait_idle();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= t;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        trim_setting = t;
    endtask

    function automatic logic [31:0] rand_sample();
        case ($urandom_range(0, 3))
            0: return 32'hFFFF_FFFF - $urandom_range(0, 3);
            1: return $urandom_range(0, 3);
            default: return $urandom;
        endcase
    endfunction

    task automatic send_batch(input int n);
        for (int i = 0; i < n; i++) send_request(rand_sample(), 1'b1, i == n - 1, 16'($urandom));
    endtask

    task automatic test_directed();
        send_request('0, 1'b0, 1'b1, 16'hFFFF);
        send_request(32'hFFFF_FFFF, 1'b1, 1'b1, 16'h0000);
        send_request(32'h0000_0000, 1'b0, 1'b0, 16'h1234);
        send_request(32'hFFFF_FFFF, 1'b1, 1'b0, 16'h0);
        send_request(32'hFFFF_FFFE, 1'b1, 1'b0, 16'h0);
        send_request(32'h0000_0001, 1'b1, 1'b0, 16'h0);
        send_request(32'h8000_0000, 1'b1, 1'b1, 16'hA5A5);
        send_request(32'h5555_5555, 1'b1, 1'b0, 16'h0);
        send_request(32'hAAAA_AAAA, 1'b1, 1'b0, 16'h0);
        send_request('0, 1'b0, 1'b1, 16'h5A5A);
    endtask

    task automatic test_trim_settings();
        logic [7:0] trims[6] = '{8'd128, 8'd255, 8'd1, 8'd64, 8'd13, 8'd0};
        foreach (trims[k]) begin
            write_trim(trims[k]);
            for (int b = 1; b <= 6; b++) send_batch(b);
            send_batch(20);
        end
    endtask

    task automatic test_overflow();
        write_trim(8'd26);
        for (int i = 0; i < MAX_N + 3; i++) send_request($urandom, 1'b1, 1'b0, '0);
        send_request(32'h1, 1'b1, 1'b1, 16'hBEEF);
        send_request(32'h2, 1'b1, 1'b1, 16'h0001);
    endtask

    task automatic test_random();
        int sent;
        write_trim(8'($urandom_range(0, 128)));
        sent = 0;
        while (sent < 700) begin
            int n;
            n = $urandom_range(0, 30);
            for (int i = 0; i < n; i++) begin
                send_request(rand_sample(), $urandom_range(0, 7) != 0, 1'b0, 16'($urandom));
                sent++;
            end
            send_request(rand_sample(), $urandom_range(0, 1), 1'b1, 16'($urandom));
            sent++;
            if (sent > 500) gaps_on = 1'b0;
        end
    endtask

    initial begin
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_trim_settings();
        test_overflow();
        test_random();
        wait_idle();
        if (mismatch_count == 0 && stats_expected.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/srs_pkg.sv
design/srs_if.sv
design/srs_cell.sv
design/srs_div.sv
design/sample_rank_statistics_unit.sv
dv/sample_rank_statistics_unit_test.sv
